/* rtl/bioa_pkg.sv */
// ----------------------------------------------------------------------------
// bioa_pkg
// Shared types and constants of the block item offset allocator.
// ----------------------------------------------------------------------------
package bioa_pkg;

   localparam int unsigned LEN_W = 24;
   localparam int unsigned CNT_W = 23;

   localparam logic [LEN_W-1:0] HEADER_BYTES     = 24'd8;
   localparam logic [LEN_W-1:0] KEY_SPACE_BYTES  = 24'd8;
   localparam logic [LEN_W-1:0] NARROW_LIMIT     = 24'd64512;
   localparam int unsigned      WIDE_ENTRY_BYTES = 3;

   localparam logic [LEN_W-1:0] BUFFER_BYTES_RST = 24'd32768;
   localparam int unsigned      TABLE_BYTES_RST  = 16384;
   localparam logic [CNT_W-1:0] NARROW_LIM_RST   = CNT_W'(TABLE_BYTES_RST / 2);
   localparam logic [CNT_W-1:0] WIDE_LIM_RST     = CNT_W'(TABLE_BYTES_RST / WIDE_ENTRY_BYTES);

   // reciprocal for table_bytes / WIDE_ENTRY_BYTES, exact for 24-bit inputs
   localparam int unsigned      RECIP_SHIFT = 25;
   localparam logic [24:0]      WIDE_RECIP  =
      25'(((64'd1 << RECIP_SHIFT) + WIDE_ENTRY_BYTES - 1) / WIDE_ENTRY_BYTES);

   localparam int unsigned      CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_BYTES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_BYTES       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE_KEY_SPACE = 2'd2;

   typedef enum logic [1:0] {
      FUNC_START  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef struct packed {
      func_type         func;
      logic [LEN_W-1:0] record_length;
   } req_type;

   typedef struct packed {
      logic             accepted;
      logic [LEN_W-1:0] record_offset;
      logic             wide_entries;
      logic [CNT_W-1:0] records_held;
      logic [LEN_W-1:0] formed_length;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] buffer_bytes;
      logic [CNT_W-1:0] narrow_limit;
      logic [CNT_W-1:0] wide_limit;
      logic             reserve_key_space;
   } cfg_type;

endpackage

/* rtl/bioa_cfg.sv */
// ----------------------------------------------------------------------------
// bioa_cfg
// Configuration registers; table entry limits are worked out at write time.
// ----------------------------------------------------------------------------
module bioa_cfg
   import bioa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [48:0] recip_prod;

   assign recip_prod = 49'(csr_wdata) * 49'(WIDE_RECIP);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BUFFER_BYTES: begin
               cfg_in.buffer_bytes = csr_wdata;
            end
            CSR_TABLE_BYTES: begin
               cfg_in.narrow_limit = csr_wdata[LEN_W-1:1];
               cfg_in.wide_limit   = recip_prod[RECIP_SHIFT+CNT_W-1:RECIP_SHIFT];
            end
            CSR_RESERVE_KEY_SPACE: begin
               cfg_in.reserve_key_space = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_bytes      <= BUFFER_BYTES_RST;
         cfg_ff.narrow_limit      <= NARROW_LIM_RST;
         cfg_ff.wide_limit        <= WIDE_LIM_RST;
         cfg_ff.reserve_key_space <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/bioa_core.sv */
// ----------------------------------------------------------------------------
// bioa_core
// Allocator state and the single-pass start / append / finish logic.
// ----------------------------------------------------------------------------
module bioa_core
   import bioa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fire,
   input  req_type req,
   output rsp_type rsp
);

   logic [LEN_W-1:0] write_offset_ff, write_offset_in;
   logic [LEN_W-1:0] data_bytes_ff,   data_bytes_in;
   logic [CNT_W-1:0] record_count_ff, record_count_in;
   logic [CNT_W-1:0] count_limit_ff,  count_limit_in;
   logic             wide_mode_ff,    wide_mode_in;

   logic [LEN_W:0]   new_len;
   logic [LEN_W+1:0] new_even;
   logic [LEN_W+2:0] narrow_total;
   logic [LEN_W:0]   wide_tab;
   logic [LEN_W+1:0] wide_tab_even;
   logic [LEN_W+2:0] wide_total;
   logic             narrow_path;
   logic             append_ok;
   logic [LEN_W:0]   fin_tab;
   logic [LEN_W+1:0] fin_tab_even;
   logic [LEN_W:0]   fin_data_even;
   logic [LEN_W+2:0] formed;
   logic [LEN_W-1:0] key_bytes;

   assign new_len  = {1'b0, data_bytes_ff} + {1'b0, req.record_length};
   assign new_even = ({1'b0, new_len} + (LEN_W+2)'(1)) & ~(LEN_W+2)'(1);

   assign narrow_total = (LEN_W+3)'(HEADER_BYTES) + (LEN_W+3)'(new_even)
                       + (LEN_W+3)'({record_count_ff, 1'b0}) + (LEN_W+3)'(2);

   // table size once this record is in, wide entries
   assign wide_tab      = (LEN_W+1)'(record_count_ff) * (LEN_W+1)'(WIDE_ENTRY_BYTES)
                        + (LEN_W+1)'(WIDE_ENTRY_BYTES);
   assign wide_tab_even = ({1'b0, wide_tab} + (LEN_W+2)'(1)) & ~(LEN_W+2)'(1);
   assign wide_total    = (LEN_W+3)'(HEADER_BYTES) + (LEN_W+3)'(new_even)
                        + (LEN_W+3)'(wide_tab_even);

   assign narrow_path = !wide_mode_ff && (write_offset_ff <= NARROW_LIMIT);

   always_comb begin
      append_ok = 1'b0;
      if (record_count_ff < count_limit_ff) begin
         if (narrow_path) begin
            append_ok = narrow_total <= (LEN_W+3)'(cfg.buffer_bytes);
         end else begin
            // a rejected append never widens the table
            append_ok = (wide_total <= (LEN_W+3)'(cfg.buffer_bytes))
                     && (wide_mode_ff || (record_count_ff < cfg.wide_limit));
         end
      end
   end

   assign fin_tab       = wide_mode_ff ?
                          (LEN_W+1)'(record_count_ff) * (LEN_W+1)'(WIDE_ENTRY_BYTES) :
                          (LEN_W+1)'({record_count_ff, 1'b0});
   assign fin_tab_even  = ({1'b0, fin_tab} + (LEN_W+2)'(1)) & ~(LEN_W+2)'(1);
   assign fin_data_even = ({1'b0, data_bytes_ff} + (LEN_W+1)'(1)) & ~(LEN_W+1)'(1);
   assign formed        = (LEN_W+3)'(HEADER_BYTES) + (LEN_W+3)'(fin_data_even)
                        + (LEN_W+3)'(fin_tab_even);

   assign key_bytes = cfg.reserve_key_space ? KEY_SPACE_BYTES : '0;

   always_comb begin
      write_offset_in     = write_offset_ff;
      data_bytes_in       = data_bytes_ff;
      record_count_in     = record_count_ff;
      count_limit_in      = count_limit_ff;
      wide_mode_in        = wide_mode_ff;
      rsp.accepted        = 1'b0;
      rsp.record_offset   = '0;
      rsp.formed_length   = '0;
      unique case (req.func)
         FUNC_START: begin
            data_bytes_in   = key_bytes;
            write_offset_in = HEADER_BYTES + key_bytes;
            record_count_in = '0;
            count_limit_in  = cfg.narrow_limit;
            wide_mode_in    = 1'b0;
            rsp.accepted    = 1'b1;
         end
         FUNC_APPEND: begin
            if (append_ok) begin
               write_offset_in   = write_offset_ff + req.record_length;
               data_bytes_in     = new_len[LEN_W-1:0];
               record_count_in   = record_count_ff + CNT_W'(1);
               rsp.accepted      = 1'b1;
               rsp.record_offset = write_offset_ff;
               if (!narrow_path) begin
                  wide_mode_in = 1'b1;
                  if (!wide_mode_ff) begin
                     count_limit_in = cfg.wide_limit;
                  end
               end
            end
         end
         FUNC_FINISH: begin
            rsp.accepted      = 1'b1;
            rsp.formed_length = (formed > (LEN_W+3)'({LEN_W{1'b1}})) ?
                                {LEN_W{1'b1}} : formed[LEN_W-1:0];
         end
         FUNC_NONE: begin
            rsp.accepted = 1'b0;
         end
      endcase
      rsp.wide_entries = wide_mode_in;
      rsp.records_held = record_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_offset_ff <= HEADER_BYTES;
         data_bytes_ff   <= '0;
         record_count_ff <= '0;
         count_limit_ff  <= '0;
         wide_mode_ff    <= 1'b0;
      end else if (fire) begin
         write_offset_ff <= write_offset_in;
         data_bytes_ff   <= data_bytes_in;
         record_count_ff <= record_count_in;
         count_limit_ff  <= count_limit_in;
         wide_mode_ff    <= wide_mode_in;
      end
   end

endmodule

/* rtl/block_item_offset_allocator_core.sv */
// ----------------------------------------------------------------------------
// block_item_offset_allocator_core
// Gives byte offsets for records packed into a fixed-size storage block.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid, req_stall | func, record_length
//  rsp_    | out       | rsp_valid, rsp_stall | accepted, record_offset,
//          |           |                      | wide_entries, records_held,
//          |           |                      | formed_length
//  csr_    | in        | csr_we               | csr_index, csr_wdata
//
// one request per cycle sustained unless rsp_stall holds a valid result;
// a taken request is registered, then fires into the result register on
// the rsp_ ports as the allocator state updates. reset is synchronous and
// resets state and limits and clears both valid flags. req_stall rises only
// when the request register is full and a stalled result holds its register.
// ----------------------------------------------------------------------------
module block_item_offset_allocator_core
   import bioa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [LEN_W-1:0]     req_record_length,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accepted,
   output logic [LEN_W-1:0]     rsp_record_offset,
   output logic                 rsp_wide_entries,
   output logic [CNT_W-1:0]     rsp_records_held,
   output logic [LEN_W-1:0]     rsp_formed_length,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wdata
);

   cfg_type cfg;
   req_type req_ff, req_in;
   logic    req_valid_ff;
   rsp_type rsp_ff, rsp_next;
   logic    rsp_valid_ff;
   logic    out_free;
   logic    fire;

   bioa_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bioa_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (fire),
      .req   (req_ff),
      .rsp   (rsp_next)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   assign req_in.func          = func_type'(req_func);
   assign req_in.record_length = req_record_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_ff.accepted;
   assign rsp_record_offset = rsp_ff.record_offset;
   assign rsp_wide_entries  = rsp_ff.wide_entries;
   assign rsp_records_held  = rsp_ff.records_held;
   assign rsp_formed_length = rsp_ff.formed_length;

endmodule

/* rtl/bioa_checker.sv */
// ----------------------------------------------------------------------------
// bioa_checker
// Port-level checks on the result channel of the offset allocator.
// ----------------------------------------------------------------------------
module bioa_checker
   import bioa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_stall,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_accepted,
   input  logic [LEN_W-1:0]     rsp_record_offset,
   input  logic                 rsp_wide_entries,
   input  logic [CNT_W-1:0]     rsp_records_held,
   input  logic [LEN_W-1:0]     rsp_formed_length
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_record_offset) && $stable(rsp_formed_length)
         && $stable(rsp_records_held) && $stable(rsp_wide_entries))
      else $error("result changed while stalled");

   // a reject carries no offset and no length
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_record_offset == '0 && rsp_formed_length == '0)
      else $error("rejected result carries data");

   // a formed length only comes from a finish, which has no offset
   a_finish_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_formed_length != '0 |-> rsp_accepted && rsp_record_offset == '0)
      else $error("formed length on a non-finish result");

   // no result straight out of reset, and no stall towards requests either
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("channel active right after reset");

endmodule

bind block_item_offset_allocator_core bioa_checker u_bioa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_accepted      (rsp_accepted),
   .rsp_record_offset (rsp_record_offset),
   .rsp_wide_entries  (rsp_wide_entries),
   .rsp_records_held  (rsp_records_held),
   .rsp_formed_length (rsp_formed_length)
);
